// ----- rtl/torus_neighbour_count_fitness_defines.svh -----
// Assertion macros for the torus neighbour-count fitness block.
// Used by the port checker; each macro expects clk and rst_n in scope.
`ifndef TORUS_NEIGHBOUR_COUNT_FITNESS_DEFINES_SVH
`define TORUS_NEIGHBOUR_COUNT_FITNESS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define TNC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define TNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tnc_pkg.sv -----
// Shared types and constants of the torus neighbour-count fitness block.
// No dependencies; imported by every module of the block but tnc_ram.
package tnc_pkg;

  // Population size and derived widths
  localparam int MAX_AGENTS = 64;
  localparam int AW         = $clog2(MAX_AGENTS);
  localparam int CW         = $clog2(MAX_AGENTS + 1);

  // Field widths
  localparam int POS_W  = 16;
  localparam int RAD_W  = 15;
  localparam int WGT_W  = 16;
  localparam int FIT_W  = 20;
  localparam int FRAC_W = 16;

  // Squared distances and radius
  localparam int SQ_W  = 2 * POS_W;
  localparam int R2_W  = 2 * RAD_W;
  localparam logic [POS_W-1:0] HALF_SIDE = POS_W'(1) << (POS_W - 1);

  // Square root unit: one result bit per step
  localparam int ROOT_STEPS = FIT_W;
  localparam int VAL_W      = 2 * ROOT_STEPS;
  localparam int REM_W      = FIT_W + 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int COST_W     = WGT_W + CW;

  // Stream and register port widths
  localparam int IN_TDATA_W  = 2 * POS_W;
  localparam int OUT_BITS    = AW + CW + FIT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_SWEEP,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } tnc_state_t;

  // Status of the pair-check pipeline
  typedef struct packed {
    logic busy;
    logic hit;
  } pair_stat_t;

endpackage

// ----- rtl/tnc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module tnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tnc_pair.sv -----
// Pair-check pipeline: wrapped deltas, squares, compare against radius squared.
// Depends on tnc_pkg.
module tnc_pair (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pair_vld,
  input  logic [tnc_pkg::POS_W-1:0]  xi,
  input  logic [tnc_pkg::POS_W-1:0]  yi,
  input  logic [tnc_pkg::POS_W-1:0]  xj,
  input  logic [tnc_pkg::POS_W-1:0]  yj,
  input  logic [tnc_pkg::RAD_W-1:0]  radius,
  output tnc_pkg::pair_stat_t        stat
);
  import tnc_pkg::*;

  logic [POS_W-1:0] dx_raw, dy_raw;
  logic [POS_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]  sx_r, sy_r;
  logic [SQ_W:0]    dist2;
  logic [R2_W-1:0]  r2_r;
  logic             s1_vld_r, s2_vld_r, hit_r, hit_vld_r;

  // Minimum image: fold deltas above half a side
  assign dx_raw = xi - xj;
  assign dy_raw = yi - yj;

  // Stage 1: folded deltas
  always_ff @(posedge clk) begin
    dx_r <= (dx_raw > HALF_SIDE) ? (POS_W'(0) - dx_raw) : dx_raw;
    dy_r <= (dy_raw > HALF_SIDE) ? (POS_W'(0) - dy_raw) : dy_raw;
  end

  // Stage 2: squares; radius squared held alongside
  always_ff @(posedge clk) begin
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    r2_r <= radius * radius;
  end

  // Stage 3: strict compare
  assign dist2 = {1'b0, sx_r} + {1'b0, sy_r};

  always_ff @(posedge clk) begin
    hit_r <= dist2 < (SQ_W + 1)'(r2_r);
  end

  // Track valid through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      hit_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= pair_vld;
      s2_vld_r  <= s1_vld_r;
      hit_vld_r <= s2_vld_r;
    end
  end

  assign stat.busy = s1_vld_r | s2_vld_r | hit_vld_r;
  assign stat.hit  = hit_vld_r & hit_r;

endmodule

// ----- rtl/tnc_fit.sv -----
// Fitness unit: bit-serial square root of count, minus weight times count.
// Depends on tnc_pkg.
module tnc_fit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tnc_pkg::CW-1:0]    count,
  input  logic [tnc_pkg::WGT_W-1:0] weight,
  output logic                      done,
  output logic [tnc_pkg::FIT_W-1:0] fitness
);
  import tnc_pkg::*;

  logic [VAL_W-1:0]  v_r;
  logic [REM_W-1:0]  rem_r;
  logic [FIT_W-1:0]  root_r;
  logic [COST_W-1:0] cost_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [REM_W+1:0]  rem_sh, trial;
  logic [COST_W-1:0] root_ext;

  // One root bit per step: bring down two radicand bits, try to subtract
  assign rem_sh = {rem_r, v_r[VAL_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= VAL_W'(count) << (2 * FRAC_W);
      rem_r  <= '0;
      root_r <= '0;
      cost_r <= weight * count;
    end else if (busy_r) begin
      v_r <= v_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[FIT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[FIT_W-2:0], 1'b0};
      end
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Clamp the difference at zero
  assign root_ext = COST_W'(root_r);
  assign fitness  = (root_ext > cost_r) ? FIT_W'(root_ext - cost_r) : '0;
  assign done     = done_r;

endmodule

// ----- rtl/torus_neighbour_count_fitness.sv -----
// Top level of the torus neighbour-count fitness block.
// Depends on tnc_pkg, tnc_ram, tnc_pair and tnc_fit.
//
// Agents load one per cycle into a 64-entry position memory; the request with
// tlast closes the population (a request beyond 64 agents is dropped, but its
// tlast still counts). Then, for each agent i in load order, the block reads
// entry i and sweeps all N entries through the single memory read port, one
// pair per cycle, counting pairs whose wrapped distance is strictly below the
// radius. A 20-step square root follows, and the result is offered on the
// output stream. Each agent passes through a row read, the sweep, a pipeline
// drain, the root and an emit state that holds while the output stalls.
// No input is taken from the final request until the last result is accepted.
// Registers: radius at address 0, competition weight at address 4; write them
// only while idle.
module torus_neighbour_count_fitness (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream; tdata: pos_x [15:0], pos_y [31:16]; tlast: final_agent
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tnc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  // Result stream; tdata: agent_index [5:0], neighbour_count [12:6],
  // fitness [32:13], zero pad [39:33]; tlast: last_result
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tnc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  // Register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tnc_pkg::PADDR_W-1:0]       cfg_paddr,
  input  logic [tnc_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [tnc_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import tnc_pkg::*;

  tnc_state_t       state_r, state_nxt;
  logic [RAD_W-1:0] radius_r;
  logic [WGT_W-1:0] weight_r;
  logic [CW-1:0]    loaded_r, last_idx;
  logic [AW-1:0]    row_r, col_r;
  logic [CW-1:0]    cnt_r;
  logic             latch_row_r, pair_vld_r;
  logic [POS_W-1:0] xi_r, yi_r;
  logic             in_acc, out_acc, ram_we, row_last, col_last;
  logic [AW-1:0]    raddr;
  logic [2*POS_W-1:0] rdata;
  pair_stat_t       pstat;
  logic             fit_start, fit_done;
  logic [FIT_W-1:0] fit_val;
  logic [AW-1:0]    out_idx_r;
  logic [CW-1:0]    out_cnt_r;
  logic [FIT_W-1:0] out_fit_r;
  logic             out_vld_r, out_last_r;

  // Register port
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(655);
      weight_r <= WGT_W'(16384);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[2])
        REG_RADIUS: radius_r <= cfg_pwdata[RAD_W-1:0];
        REG_WEIGHT: weight_r <= cfg_pwdata[WGT_W-1:0];
        default:    radius_r <= radius_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_RADIUS: cfg_prdata = PDATA_W'(radius_r);
      REG_WEIGHT: cfg_prdata = PDATA_W'(weight_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Handshakes
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_vld_r && out_tready;

  // Position memory: {y, x} per agent
  assign ram_we   = in_acc && (loaded_r < CW'(MAX_AGENTS));
  assign raddr    = (state_r == ST_ROW) ? row_r : col_r;
  assign last_idx = loaded_r - CW'(1);
  assign row_last = ({1'b0, row_r} == last_idx);
  assign col_last = ({1'b0, col_r} == last_idx);

  tnc_ram #(
    .WIDTH (2 * POS_W),
    .DEPTH (MAX_AGENTS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (loaded_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Hold the row agent; it arrives the cycle after its read
  always_ff @(posedge clk) begin
    if (latch_row_r) begin
      xi_r <= rdata[POS_W-1:0];
      yi_r <= rdata[2*POS_W-1:POS_W];
    end
  end

  tnc_pair u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .pair_vld (pair_vld_r),
    .xi       (xi_r),
    .yi       (yi_r),
    .xj       (rdata[POS_W-1:0]),
    .yj       (rdata[2*POS_W-1:POS_W]),
    .radius   (radius_r),
    .stat     (pstat)
  );

  tnc_fit u_fit (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (fit_start),
    .count   (cnt_r),
    .weight  (weight_r),
    .done    (fit_done),
    .fitness (fit_val)
  );

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    fit_start = 1'b0;
    unique case (state_r)
      ST_LOAD:  if (in_acc && in_tlast) state_nxt = ST_ROW;
      ST_ROW:   state_nxt = ST_SWEEP;
      ST_SWEEP: if (col_last) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (!pair_vld_r && !pstat.busy) begin
          fit_start = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT:  if (fit_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) begin
          state_nxt = row_last ? ST_LOAD : ST_ROW;
        end
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Counters and read tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      latch_row_r <= 1'b0;
      pair_vld_r  <= 1'b0;
    end else begin
      latch_row_r <= (state_r == ST_ROW);
      pair_vld_r  <= (state_r == ST_SWEEP);
      if (ram_we) begin
        loaded_r <= loaded_r + CW'(1);
      end
      if (in_acc && in_tlast) begin
        row_r <= '0;
      end
      if (state_r == ST_ROW) begin
        col_r <= '0;
        cnt_r <= '0;
      end else if (pstat.hit) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (state_r == ST_SWEEP) begin
        col_r <= col_r + AW'(1);
      end
      if (out_acc) begin
        if (row_last) begin
          loaded_r <= '0;
        end else begin
          row_r <= row_r + AW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (fit_done) begin
      out_idx_r  <= row_r;
      out_cnt_r  <= cnt_r;
      out_fit_r  <= fit_val;
      out_last_r <= row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fit_done) begin
      out_vld_r <= 1'b1;
    end else if (out_acc) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_fit_r, out_cnt_r, out_idx_r});

endmodule

// ----- rtl/tnc_check.sv -----
// Port checker for the torus neighbour-count fitness block, bound to its top.
// Depends on tnc_pkg and torus_neighbour_count_fitness_defines.svh.
`include "torus_neighbour_count_fitness_defines.svh"

module tnc_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tnc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import tnc_pkg::*;

  // Hold a stalled result
  `TNC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Loading and result delivery never overlap
  `TNC_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready, "input taken while a result is pending")

  // Final request closes the input until results are done
  `TNC_ASSERT_NEXT(a_final_closes, in_tvalid && in_tready && in_tlast, !in_tready, "input still open after final request")

  // Last result returns the block to loading
  `TNC_ASSERT_NEXT(a_last_reopens, out_tvalid && out_tready && out_tlast, !out_tvalid && in_tready, "block not back to loading after last result")

  // Count never exceeds the maximum population
  `TNC_ASSERT_NOW(a_count_range, out_tvalid, out_tdata[12:6] <= 7'(MAX_AGENTS), "neighbour count out of range")

endmodule

bind torus_neighbour_count_fitness tnc_check u_tnc_check (.*);

// ----- tb/torus_neighbour_count_fitness_tb.sv -----
// Testbench for torus_neighbour_count_fitness: a directed table, then random
// agent populations, every result checked against an in-bench neighbour count
// or a typed table value. Depends on tnc_pkg and the block's RTL; needs nothing else.
`timescale 1ns / 1ps

module torus_neighbour_count_fitness_tb;
  import tnc_pkg::*;

  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 40;    // about one agent's pass when idle
  localparam int HOLD_AFTER    = 40;    // results seen before the long hold-off
  localparam int HOLD_CYCLES   = 400;
  // Longest correct gap: hold-off plus one agent's sweep, root and stalls
  localparam int QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic [AW-1:0]    agent_idx;
    logic [CW-1:0]    nbr_count;
    logic [FIT_W-1:0] fitness;
    logic             closing;
  } agent_fitness_t;

  typedef enum logic [1:0] {STEP_AGENT, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic             reg_sel;
    logic [15:0]      value;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic             fin;
    logic             typed;
    logic [CW-1:0]    want_count;
    logic [FIT_W-1:0] want_fit;
  } directed_step_t;

  // Typed results hold for every agent of the population closed by that row
  localparam directed_step_t DIRECTED [0:19] = '{
    // one agent right after reset: root 1.0 minus 0.25
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h0000, 16'h0000, 1'b1, 1'b1, 7'd1, 20'd49152},
    // corners one step apart across the wrap: count 2, sqrt(2) - 0.5
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 7'd2, 20'd59913},
    // half-side offsets
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h8000, 16'h0000, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h0000, 16'h8000, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 7'd0, 20'd0},
    // zero radius: nothing counts, not even the agent itself
    '{STEP_WRITE, REG_RADIUS, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h1234, 16'h5678, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h1234, 16'h5678, 1'b1, 1'b1, 7'd0, 20'd0},
    // widest radius, free competition
    '{STEP_WRITE, REG_RADIUS, 16'h7FFF, 16'h0, 16'h0, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_WRITE, REG_WEIGHT, 16'h0000, 16'h0, 16'h0, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h0000, 16'h0000, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h8000, 16'h8000, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h4000, 16'hC000, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 7'd1, 20'd65536},
    // heaviest weight: one agent keeps a single LSB, two clamp to zero
    '{STEP_WRITE, REG_WEIGHT, 16'hFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 7'd1, 20'd1},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h0F0F, 16'hF0F0, 1'b0, 1'b0, 7'd0, 20'd0},
    '{STEP_AGENT, REG_RADIUS, 16'h0, 16'h0F0F, 16'hF0F0, 1'b1, 1'b1, 7'd2, 20'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [PADDR_W-1:0]     cfg_paddr;
  logic [PDATA_W-1:0]     cfg_pwdata;
  logic [PDATA_W-1:0]     cfg_prdata;
  logic                   cfg_pready;

  // Neighbour-count model state
  logic [POS_W-1:0] pop_x [MAX_AGENTS];
  logic [POS_W-1:0] pop_y [MAX_AGENTS];
  int               pop_size;
  logic [RAD_W-1:0] radius_q;
  logic [WGT_W-1:0] weight_q;
  agent_fitness_t   fitness_due [$];

  int burst_left;
  int agents_sent;
  int populations_closed;
  int settings_written;
  int results_seen;
  int mismatches;

  torus_neighbour_count_fitness dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Offer one agent, wait for its request to be taken, then predict.
  // Valid stays high into the next call unless the burst ends here.
  task automatic offer_agent(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                             input logic fin, input logic typed,
                             input logic [CW-1:0] want_count,
                             input logic [FIT_W-1:0] want_fit);
    logic [POS_W-1:0] d;
    logic [POS_W:0]   dx, dy;
    logic [63:0]      dist2, r2, root, trial, scaled, cost;
    int               hits;
    agent_fitness_t   entry;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    agents_sent++;

    // Store unless the population is already full
    if (pop_size < MAX_AGENTS) begin
      pop_x[pop_size] = px;
      pop_y[pop_size] = py;
      pop_size++;
    end

    // Close the population: count wrapped neighbours, then root minus cost
    if (fin) begin
      r2 = 64'(radius_q) * 64'(radius_q);
      for (int i = 0; i < pop_size; i++) begin
        hits = 0;
        for (int j = 0; j < pop_size; j++) begin
          d  = pop_x[i] - pop_x[j];
          dx = (d > HALF_SIDE) ? 17'h10000 - {1'b0, d} : {1'b0, d};
          d  = pop_y[i] - pop_y[j];
          dy = (d > HALF_SIDE) ? 17'h10000 - {1'b0, d} : {1'b0, d};
          dist2 = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
          if (dist2 < r2) hits++;
        end
        scaled = 64'(hits) << 32;
        root   = 0;
        for (int b = FIT_W - 1; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= scaled) root = trial;
        end
        cost = 64'(weight_q) * 64'(hits);
        entry.agent_idx = AW'(i);
        entry.nbr_count = CW'(hits);
        entry.fitness   = (root > cost) ? FIT_W'(root - cost) : '0;
        entry.closing   = (i == pop_size - 1);
        if (typed) begin
          entry.nbr_count = want_count;
          entry.fitness   = want_fit;
        end
        fitness_due.push_back(entry);
      end
      pop_size = 0;
      populations_closed++;
    end

    // End of burst: drop valid for a random gap
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Drain every pending result, let the block settle, then write one register
  task automatic write_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (fitness_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'({reg_sel, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_sel == REG_RADIUS) radius_q = value[RAD_W-1:0];
    else weight_q = value[WGT_W-1:0];
    settings_written++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Result sink: rotating ready mask, one long hold-off mid-run
  initial begin : result_sink
    int          age;
    logic [15:0] mask;
    logic        hold_done;
    out_tready = 1'b0;
    age        = 0;
    mask       = '1;
    hold_done  = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (age == 0) begin
        age = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: mask = '1;
          1: mask = 16'($urandom);
          2: mask = 16'($urandom | $urandom);
          default: mask = 16'($urandom & $urandom);
        endcase
      end
      age--;
      out_tready <= mask[0];
      mask = {mask[0], mask[15:1]};
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    agent_fitness_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.agent_idx = out_tdata[AW-1:0];
      got.nbr_count = out_tdata[AW+CW-1:AW];
      got.fitness   = out_tdata[AW+CW+FIT_W-1:AW+CW];
      got.closing   = out_tlast;
      if (fitness_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: agent %0d count %0d fitness %0d last %0b",
                   got.agent_idx, got.nbr_count, got.fitness, got.closing);
        mismatches++;
      end else begin
        want = fitness_due.pop_front();
        if (got != want) begin
          if (mismatches < 10)
            $display({"result mismatch: expected agent %0d count %0d fitness %0d last %0b,",
                      " got agent %0d count %0d fitness %0d last %0b"},
                     want.agent_idx, want.nbr_count, want.fitness, want.closing,
                     got.agent_idx, got.nbr_count, got.fitness, got.closing);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int               random_start;
    int               phase;
    int               pops;
    int               n;
    int               span;
    logic [15:0]      rad;
    logic [15:0]      wgt;
    logic [POS_W-1:0] cx, cy, px, py;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    pop_size    = 0;
    radius_q    = RAD_W'(655);
    weight_q    = WGT_W'(16384);
    burst_left  = $urandom_range(1, 10);
    agents_sent = 0;
    populations_closed = 0;
    settings_written   = 0;
    results_seen       = 0;
    mismatches         = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int k = 0; k < $size(DIRECTED); k++) begin
      if (DIRECTED[k].kind == STEP_WRITE)
        write_register(DIRECTED[k].reg_sel, PDATA_W'(DIRECTED[k].value));
      else
        offer_agent(DIRECTED[k].px, DIRECTED[k].py, DIRECTED[k].fin, DIRECTED[k].typed,
                    DIRECTED[k].want_count, DIRECTED[k].want_fit);
    end

    // Random phases; each register write first drains every pending result.
    // Phase zero overfills one population with a tight cluster at the widest
    // radius and zero weight, then keeps offering while its results drain.
    random_start = agents_sent;
    phase = 0;
    while (agents_sent - random_start < RANDOM_ITEMS) begin
      if (phase == 0) begin
        rad = 16'h7FFF;
        wgt = 16'h0000;
      end else begin
        case ($urandom_range(0, 5))
          0: rad = 16'd1;
          1: rad = 16'h7FFF;
          2: rad = 16'($urandom_range(1, 32767));
          3, 4: rad = 16'($urandom_range(100, 3000));
          default: rad = 16'd0;
        endcase
        case ($urandom_range(0, 4))
          0: wgt = 16'h0000;
          1: wgt = 16'hFFFF;
          2: wgt = 16'($urandom);
          default: wgt = 16'($urandom_range(0, 20000));
        endcase
      end
      write_register(REG_RADIUS, PDATA_W'(rad));
      write_register(REG_WEIGHT, PDATA_W'(wgt));

      pops = (phase == 0) ? 3 : $urandom_range(2, 5);
      for (int p = 0; p < pops; p++) begin
        if (phase == 0 && p == 0) n = MAX_AGENTS + 2;
        else if ($urandom_range(0, 7) == 0) n = $urandom_range(9, 20);
        else n = $urandom_range(1, 8);
        span = (rad == 0) ? 64 : ((rad > 8000) ? 8000 : int'(rad));
        cx = POS_W'($urandom);
        cy = POS_W'($urandom);
        for (int a = 0; a < n; a++) begin
          // Mostly cluster around the center so neighbours are found
          if ((phase == 0 && p == 0) || $urandom_range(0, 3) != 0) begin
            px = cx + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
            py = cy + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
          end else begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
          end
          offer_agent(px, py, a == n - 1, 1'b0, '0, '0);
        end
      end
      phase++;
    end

    // Drain, settle, and report
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (fitness_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fitness_due.size() != 0) begin
      $display("%0d expected results never arrived", fitness_due.size());
      mismatches += fitness_due.size();
    end
    $display("run covered %0d agents in %0d populations over %0d register writes",
             agents_sent, populations_closed, settings_written);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tnc_pkg.sv
rtl/tnc_ram.sv
rtl/tnc_pair.sv
rtl/tnc_fit.sv
rtl/torus_neighbour_count_fitness.sv
rtl/tnc_check.sv
tb/torus_neighbour_count_fitness_tb.sv
